>>> design/tch_pkg.sv
// Shared types, register indexes and helper functions for the calibrated touch block.
// Used by the controller, the datapath and the top level; depends on nothing else.
package tch_pkg;

  localparam int RawW     = 10;
  localparam int ScreenW  = 16;
  localparam int CoefW    = 32;
  localparam int DivW     = 31;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int ProdW    = CoefW + RawW + 1;   // signed coef times unsigned raw
  localparam int SumW     = ProdW + 1;          // two products plus an offset
  localparam int DivSteps = SumW;               // one quotient bit per step
  localparam int CntW     = $clog2(DivSteps);
  localparam int HeldW    = 32;

  localparam logic [CfgIdxW-1:0] RegCoefXx  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefXy  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetX = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefYx  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefYy  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOffsetY = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDivisor = 3'd6;

  localparam logic signed [CoefW-1:0] CoefUnity = 32'sd65536;
  localparam logic [DivW-1:0]         DivReset  = 31'd65536;
  localparam logic [HeldW:0]          Slop      = 33'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic sum;
    logic div_step;
    logic finish;
  } tch_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } tch_sts_t;

  // Saturates a sign-magnitude quotient to 32-bit signed.
  function automatic logic [HeldW-1:0] sat_quot(input logic neg, input logic [SumW-1:0] mag);
    logic [HeldW-1:0] res;
    if (!neg) begin
      if (|mag[SumW-1:HeldW-1]) res = {1'b0, {(HeldW-1){1'b1}}};
      else                      res = {1'b0, mag[HeldW-2:0]};
    end else begin
      if ((|mag[SumW-1:HeldW]) || (mag[HeldW-1] && (|mag[HeldW-2:0])))
        res = {1'b1, {(HeldW-1){1'b0}}};
      else
        res = -mag[HeldW-1:0];
    end
    return res;
  endfunction

  // Floor division by four, clipped to the 16-bit signed screen range.
  function automatic logic [ScreenW-1:0] shrink(input logic [HeldW-1:0] held);
    logic signed [HeldW-3:0] s;
    logic [ScreenW-1:0]      res;
    s = $signed(held[HeldW-1:2]);
    if (s > $signed(30'sd32767))       res = 16'h7fff;
    else if (s < $signed(-30'sd32768)) res = 16'h8000;
    else                               res = s[ScreenW-1:0];
    return res;
  endfunction

endpackage

>>> design/tch_in_if.sv
// Handshake channel that carries one raw touch sample per beat.
// Depends on tch_pkg for the field widths.
interface tch_in_if;
  import tch_pkg::*;

  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_x;
  logic [RawW-1:0] raw_y;
  logic            pen_down;

  modport source (output valid, output raw_x, output raw_y, output pen_down, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input pen_down, output ready);
endinterface

>>> design/tch_out_if.sv
// Handshake channel that carries one calibrated touch report per beat.
// Depends on tch_pkg for the field widths.
interface tch_out_if;
  import tch_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ScreenW-1:0] screen_x;
  logic signed [ScreenW-1:0] screen_y;
  logic                      button_left;
  logic                      full_data;

  modport source (output valid, output screen_x, output screen_y, output button_left,
                  output full_data, input ready);
  modport sink   (input valid, input screen_x, input screen_y, input button_left,
                  input full_data, output ready);
endinterface

>>> design/tch_ctrl.sv
// Sequencer for the touch calibration block: accept, multiply, sum, divide, finish.
// Depends on tch_pkg for the command and status structs.
module tch_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tch_pkg::tch_sts_t sts_i,
  output tch_pkg::tch_cmd_t cmd_o
);
  import tch_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StFin;
      end
      StFin: begin
        // The held values and the report register change together, so wait
        // until the previous report has left.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/tch_dp.sv
// Datapath of the touch calibration block: coefficient registers, multipliers,
// two restoring dividers, hysteresis state and the report register. Depends on tch_pkg.
module tch_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tch_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tch_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic [tch_pkg::RawW-1:0]           raw_x_i,
  input  logic [tch_pkg::RawW-1:0]           raw_y_i,
  input  logic                               pen_down_i,
  input  tch_pkg::tch_cmd_t                  cmd_i,
  output tch_pkg::tch_sts_t                  sts_o,
  output logic signed [tch_pkg::ScreenW-1:0] screen_x_o,
  output logic signed [tch_pkg::ScreenW-1:0] screen_y_o,
  output logic                               button_left_o,
  output logic                               full_data_o
);
  import tch_pkg::*;

  // Configuration registers, one row per axis.
  logic signed [CoefW-1:0] coef_a_q [2];   // weight of raw x
  logic signed [CoefW-1:0] coef_b_q [2];   // weight of raw y
  logic signed [CoefW-1:0] offs_q   [2];
  logic [DivW-1:0]         dvs_q;
  logic [DivW-1:0]         dvs_eff;

  logic [RawW-1:0] x_q, y_q;
  logic            pen_q;
  logic [CntW-1:0] cnt_q;

  logic [ScreenW-1:0] scr_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q[0] <= CoefUnity;
      coef_b_q[0] <= '0;
      offs_q[0]   <= '0;
      coef_a_q[1] <= '0;
      coef_b_q[1] <= CoefUnity;
      offs_q[1]   <= '0;
      dvs_q       <= DivReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCoefXx:  coef_a_q[0] <= $signed(cfg_data_i);
        RegCoefXy:  coef_b_q[0] <= $signed(cfg_data_i);
        RegOffsetX: offs_q[0]   <= $signed(cfg_data_i);
        RegCoefYx:  coef_a_q[1] <= $signed(cfg_data_i);
        RegCoefYy:  coef_b_q[1] <= $signed(cfg_data_i);
        RegOffsetY: offs_q[1]   <= $signed(cfg_data_i);
        RegDivisor: dvs_q       <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // A zero divisor acts as one.
  assign dvs_eff = (dvs_q == '0) ? {{(DivW-1){1'b0}}, 1'b1} : dvs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q   <= raw_x_i;
      y_q   <= raw_y_i;
      pen_q <= pen_down_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sum) begin
      cnt_q <= CntW'(DivSteps - 1);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign sts_o.div_last = (cnt_q == '0);

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [ProdW-1:0] prod_a_q, prod_b_q;
    logic signed [SumW-1:0]  sum;
    logic [SumW-1:0]         mag;
    logic                    neg_q;
    logic [SumW-1:0]         quo_q;
    logic [DivW-1:0]         rem_q;
    logic [DivW:0]           trial;
    logic                    fits;
    logic [HeldW-1:0]        fresh;
    logic [HeldW:0]          diff;
    logic [HeldW:0]          gap;
    logic [HeldW-1:0]        held_q, held_new;

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul) begin
        prod_a_q <= ProdW'(coef_a_q[ax]) * ProdW'($signed({1'b0, x_q}));
        prod_b_q <= ProdW'(coef_b_q[ax]) * ProdW'($signed({1'b0, y_q}));
      end
    end

    assign sum = SumW'(prod_a_q) + SumW'(prod_b_q) + SumW'(offs_q[ax]);
    assign mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);

    // Restoring division of the magnitude, one quotient bit per step.
    assign trial = {rem_q, quo_q[SumW-1]};
    assign fits  = (trial >= {1'b0, dvs_eff});

    always_ff @(posedge clk_i) begin
      if (cmd_i.sum) begin
        neg_q <= sum[SumW-1];
        quo_q <= mag;
        rem_q <= '0;
      end else if (cmd_i.div_step) begin
        quo_q <= {quo_q[SumW-2:0], fits};
        rem_q <= fits ? DivW'(trial - {1'b0, dvs_eff}) : trial[DivW-1:0];
      end
    end

    assign fresh    = sat_quot(neg_q, quo_q);
    assign diff     = {fresh[HeldW-1], fresh} - {held_q[HeldW-1], held_q};
    assign gap      = diff[HeldW] ? -diff : diff;
    assign held_new = (gap >= Slop) ? {fresh[HeldW-1:2], 2'b00} : held_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        held_q <= '0;
      end else if (cmd_i.finish) begin
        held_q <= held_new;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.finish) scr_q[ax] <= shrink(held_new);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      button_left_o <= pen_q;
      full_data_o   <= pen_q;
    end
  end

  assign screen_x_o = $signed(scr_q[0]);
  assign screen_y_o = $signed(scr_q[1]);

endmodule

>>> design/touch_calibrate_hysteresis.sv
// Calibrated touch sample with hysteresis. Each sample is accepted and captured, multiplied,
// summed, put through 44 steps of the restoring divider (one quotient bit each, both axes in
// parallel) and then used to update the held position, which registers its report. The update
// waits for as long as an earlier report is still untaken in the output register. A new sample
// is taken once the previous one has finished, while its report may still wait in the output
// register. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i and applies to the
// next sample only if the user writes it between samples; the block itself does not enforce this.
module touch_calibrate_hysteresis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tch_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tch_pkg::CfgDataW-1:0]  cfg_data_i,
  tch_in_if.sink                        sample_i,
  tch_out_if.source                     result_o
);
  import tch_pkg::*;

  tch_cmd_t cmd;
  tch_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  tch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tch_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .raw_x_i       (sample_i.raw_x),
    .raw_y_i       (sample_i.raw_y),
    .pen_down_i    (sample_i.pen_down),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .screen_x_o    (result_o.screen_x),
    .screen_y_o    (result_o.screen_y),
    .button_left_o (result_o.button_left),
    .full_data_o   (result_o.full_data)
  );

  assign sample_i.ready = in_ready;
  assign result_o.valid = out_valid;

  // At most one step of the sequence is commanded in any cycle.
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.mul, cmd.sum, cmd.div_step, cmd.finish}))
    else $error("more than one datapath command at once");

  // A new report never overwrites one that has not been taken.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid || result_o.ready))
    else $error("report overwritten before it was taken");

  // Only one sample is in work at a time.
  a_one_in_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && in_ready) |=> !in_ready)
    else $error("sample accepted while another is in work");

  // A taken report leaves unless a new one is written in the same cycle.
  a_report_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && result_o.ready && !cmd.finish) |=> !out_valid)
    else $error("report still shown after it was taken");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for touch_calibrate_hysteresis: drives raw touch samples and checks
// every calibrated report against an in-bench prediction of the transform and hysteresis.
// Depends on design/tch_pkg.sv, design/tch_in_if.sv, design/tch_out_if.sv and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tch_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
    logic            pen;
  } touch_sample_t;

  typedef struct {
    logic signed [ScreenW-1:0] screen_x;
    logic signed [ScreenW-1:0] screen_y;
    logic                      button_left;
    logic                      full_data;
  } touch_report_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tch_in_if  smp ();
  tch_out_if rpt ();

  touch_calibrate_hysteresis uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (smp),
    .result_o   (rpt)
  );

  touch_sample_t pending_samples[$];
  touch_report_t expected_reports[$];

  // Calibration and held position as the block should see them.
  logic signed [CoefW-1:0] k_xx, k_xy, ofs_x, k_yx, k_yy, ofs_y;
  logic [DivW-1:0]         scale_div;
  logic signed [HeldW-1:0] kept_x, kept_y;

  bit idle_en;
  int fails;
  int quiet_cycles;
  int send_gap;
  int recv_stall;
  int walk_x, walk_y;

  always #6 clk_i = ~clk_i;

  // Affine map of one axis, quotient toward zero, clipped to 32-bit signed.
  function automatic longint map_axis(input logic signed [CoefW-1:0] kx, ky, ofs,
                                      input logic [DivW-1:0] dv,
                                      input logic [RawW-1:0] rx, ry);
    longint a, b, c, x, y, den, q;
    a = kx;
    b = ky;
    c = ofs;
    x = rx;
    y = ry;
    den = (dv == 0) ? 64'sd1 : longint'(dv);
    q = (a * x + b * y + c) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // A move of less than three units leaves the held value alone.
  function automatic logic signed [HeldW-1:0] settle(input longint fresh,
                                                     input logic signed [HeldW-1:0] held);
    longint diff;
    logic [HeldW-1:0] f;
    diff = fresh - longint'(held);
    if (diff < 0) diff = -diff;
    f = fresh[HeldW-1:0];
    if (diff >= 3) return {f[HeldW-1:2], 2'b00};
    return held;
  endfunction

  function automatic logic signed [ScreenW-1:0] to_screen(input logic signed [HeldW-1:0] h);
    longint q;
    q = h;
    q = q >>> 2;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[ScreenW-1:0];
  endfunction

  function automatic logic [31:0] rand_signed(input int bits);
    logic [31:0] v;
    v = $urandom;
    if (bits >= 32) return v;
    return $signed(v) >>> (32 - bits);
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Sample driver.
  always @(posedge clk_i) begin
    touch_sample_t nxt;
    if (!rst_ni) begin
      smp.valid <= 1'b0;
      send_gap  <= 0;
    end else if (!(smp.valid && !smp.ready)) begin
      if (send_gap != 0) begin
        smp.valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        smp.valid <= 1'b0;
        send_gap  <= $urandom_range(0, 8);
      end else if (pending_samples.size() != 0) begin
        nxt = pending_samples.pop_front();
        smp.valid    <= 1'b1;
        smp.raw_x    <= nxt.raw_x;
        smp.raw_y    <= nxt.raw_y;
        smp.pen_down <= nxt.pen;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // Report receiver with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rpt.ready  <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      rpt.ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rpt.ready  <= 1'b0;
      recv_stall <= $urandom_range(0, 8);
    end else begin
      rpt.ready <= 1'b1;
    end
  end

  // Prediction at each accepted sample, comparison at each accepted report, watchdog.
  always @(posedge clk_i) begin
    touch_report_t exp_r;
    bit busy;
    busy = 1'b0;
    if (!rst_ni) begin
      kept_x = '0;
      kept_y = '0;
    end else begin
      if (cfg_we) begin
        busy = 1'b1;
        case (cfg_idx)
          RegCoefXx:  k_xx = cfg_data;
          RegCoefXy:  k_xy = cfg_data;
          RegOffsetX: ofs_x = cfg_data;
          RegCoefYx:  k_yx = cfg_data;
          RegCoefYy:  k_yy = cfg_data;
          RegOffsetY: ofs_y = cfg_data;
          RegDivisor: scale_div = cfg_data[DivW-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        busy = 1'b1;
        kept_x = settle(map_axis(k_xx, k_xy, ofs_x, scale_div, smp.raw_x, smp.raw_y), kept_x);
        kept_y = settle(map_axis(k_yx, k_yy, ofs_y, scale_div, smp.raw_x, smp.raw_y), kept_y);
        exp_r.screen_x    = to_screen(kept_x);
        exp_r.screen_y    = to_screen(kept_y);
        exp_r.button_left = smp.pen_down;
        exp_r.full_data   = smp.pen_down;
        expected_reports.push_back(exp_r);
      end
      if (rpt.valid && rpt.ready) begin
        busy = 1'b1;
        if (expected_reports.size() == 0) begin
          fails++;
          $display("%0t: report beat with nothing expected, got x=%0d y=%0d", $time,
                   rpt.screen_x, rpt.screen_y);
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("screen_x", exp_r.screen_x, rpt.screen_x);
          check_field("screen_y", exp_r.screen_y, rpt.screen_y);
          check_field("button_left", exp_r.button_left, rpt.button_left);
          check_field("full_data", exp_r.full_data, rpt.full_data);
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
  endtask

  task automatic program_calib(input logic [31:0] kxx, kxy, ox, kyx, kyy, oy, dv);
    set_reg(RegCoefXx, kxx);
    set_reg(RegCoefXy, kxy);
    set_reg(RegOffsetX, ox);
    set_reg(RegCoefYx, kyx);
    set_reg(RegCoefYy, kyy);
    set_reg(RegOffsetY, oy);
    set_reg(RegDivisor, dv);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Returns at a falling edge once the block holds no sample and owes no report.
  task automatic drain();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || expected_reports.size() != 0 || smp.valid)
      @(negedge clk_i);
  endtask

  task automatic add_sample(input int x, input int y, input bit pen);
    touch_sample_t s;
    s.raw_x = x;
    s.raw_y = y;
    s.pen   = pen;
    pending_samples.push_back(s);
  endtask

  // Mostly a jittering pen track, which keeps hysteresis busy, plus some jumps.
  task automatic add_random_sample();
    if ($urandom_range(0, 3) == 0) begin
      walk_x = $urandom_range(0, 1023);
      walk_y = $urandom_range(0, 1023);
    end else begin
      walk_x = walk_x + $urandom_range(0, 10) - 5;
      walk_y = walk_y + $urandom_range(0, 10) - 5;
      if (walk_x < 0) walk_x = 0;
      if (walk_x > 1023) walk_x = 1023;
      if (walk_y < 0) walk_y = 0;
      if (walk_y > 1023) walk_y = 1023;
    end
    add_sample(walk_x, walk_y, $urandom_range(0, 1));
  endtask

  initial begin
    int kb, db;
    logic [31:0] dv;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.raw_x = '0;
    smp.raw_y = '0;
    smp.pen_down = 1'b0;
    rpt.ready = 1'b0;
    k_xx = CoefUnity;
    k_xy = '0;
    ofs_x = '0;
    k_yx = '0;
    k_yy = CoefUnity;
    ofs_y = '0;
    scale_div = DivReset;
    fails = 0;
    quiet_cycles = 0;
    walk_x = 512;
    walk_y = 512;
    idle_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset calibration maps raw to screen as raw divided by four; walk through the hysteresis edges.
    add_sample(0, 0, 1);
    add_sample(2, 2, 0);
    add_sample(3, 3, 1);
    add_sample(1023, 1023, 1);
    add_sample(1021, 1021, 0);
    add_sample(1018, 1018, 1);
    add_sample(1017, 1017, 0);
    add_sample(0, 1023, 1);
    add_sample(1023, 0, 0);
    add_sample(10'h2aa, 10'h155, 1);
    add_sample(10'h155, 10'h2aa, 0);
    drain();

    // Quotient above the 32-bit range, then clipped to the top of the screen range.
    program_calib(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'd1);
    add_sample(1023, 1023, 1);
    add_sample(0, 0, 0);
    drain();

    // Most negative weights with a zero divisor, which acts as one.
    program_calib(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'd0);
    add_sample(1023, 1023, 1);
    add_sample(0, 0, 0);
    drain();

    // Negative sums that do not divide evenly must truncate toward zero.
    program_calib(-32'sd7, 32'sd5, -32'sd5, 32'sd9, -32'sd3, 32'sd6, 32'd4);
    add_sample(1, 0, 1);
    add_sample(3, 7, 0);
    add_sample(1023, 1023, 1);
    drain();

    // Largest divisor; bit 31 of the write data lies outside the register.
    program_calib(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'hffffffff);
    add_sample(1023, 0, 1);
    add_sample(0, 1023, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      kb = $urandom_range(8, 32);
      db = kb - $urandom_range(0, 12);
      if (db < 1) db = 1;
      if (db > 31) db = 31;
      dv = ($urandom >> (32 - db)) | (32'd1 << (db - 1));
      if ($urandom_range(0, 7) == 0) dv = $urandom;
      program_calib(rand_signed(kb), rand_signed(kb - 4), rand_signed(kb + 10),
                    rand_signed(kb - 4), rand_signed(kb), rand_signed(kb + 10), dv);
      idle_en = !(ph == 5 || ph == 9);
      for (int i = 0; i < 130; i++) begin
        // Hold off the sender once until every owed report has arrived.
        if (ph == 3 && i == 65) drain();
        add_random_sample();
      end
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
